@@ sv/decaying_hit_slot_table_unit_assert.svh @@
// Assertion macros used by the slot table top level.
`ifndef DECAYING_HIT_SLOT_TABLE_UNIT_ASSERT_SVH
`define DECAYING_HIT_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DHST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DHST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dhst_pkg.sv @@
// Types and constants of the decaying hit slot table.
package dhst_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam int TAG_W     = 16;
  localparam int COORD_W   = 16;
  localparam int POS_W     = 3 * COORD_W;
  localparam int DMG_W     = 24;
  localparam int AGE_W     = 24;
  localparam int ELAPSED_W = 16;
  localparam int PROD_W    = DMG_W + ELAPSED_W;
  // damage * 4 * elapsed / 2^16 == (damage * elapsed) >> 14
  localparam int DEC_SHIFT = 14;
  localparam int DEC_W     = PROD_W - DEC_SHIFT;
  localparam int DIFF_W    = DEC_W + 1;

  localparam logic [AGE_W-1:0] AGE_ONE = 24'h010000;
  localparam logic [AGE_W-1:0] AGE_MAX = 24'hFFFFFF;
  localparam logic [DIFF_W-1:0] DAMAGE_FLOOR = DIFF_W'(2560);

  localparam int ACTIVE_W = 5;
  localparam int USED_W   = 4;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_HWRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] pos;
    logic [DMG_W-1:0] damage;
    logic [AGE_W-1:0] age;
  } slot_word_t;

endpackage

@@ sv/dhst_slot_mem.sv @@
// Slot store: one-port-read, one-port-write memory with per-entry valid bits.
module dhst_slot_mem
  import dhst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output slot_word_t               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  slot_word_t               wr_data
);

  slot_word_t       mem [SLOTS];
  logic [SLOTS-1:0] valid;
  slot_word_t       rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // Entry never written since reset reads as all zero.
  assign rd_data = rd_valid ? rd_word : '0;

endmodule

@@ sv/decaying_hit_slot_table_unit.sv @@
// Top level of the decaying hit slot table: sequencer, hit scan and tick decay.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | operation, source_tag, pos_x/y/z, hit_damage,
//          |                      | elapsed, bubble_flag
//  out     | out_valid / out_ready| active_count, slot_used, bubble_mode
//
// A hit, and a tick with a live slot, walk the slot memory one entry a cycle
// through its single read port. A tick with no live slot skips the walk.
// Reset clears the slot store at once through per-entry valid bits; no
// clearing pass. A new item is taken while a result still waits on out;
// a stalled out holds the following result in the done state.
module decaying_hit_slot_table_unit
  import dhst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [TAG_W-1:0]            source_tag,
  input  logic signed [COORD_W-1:0]   pos_x,
  input  logic signed [COORD_W-1:0]   pos_y,
  input  logic signed [COORD_W-1:0]   pos_z,
  input  logic [DMG_W-1:0]            hit_damage,
  input  logic [ELAPSED_W-1:0]        elapsed,
  input  logic                        bubble_flag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ACTIVE_W-1:0]         active_count,
  output logic [USED_W-1:0]           slot_used,
  output logic                        bubble_mode
);

`include "decaying_hit_slot_table_unit_assert.svh"

  localparam int IW  = $clog2(SLOTS);
  localparam int LCW = $clog2(SLOTS + 1);

  state_t state, state_next;

  // Held item.
  op_t                  op_r;
  logic [TAG_W-1:0]     tag_r;
  logic [POS_W-1:0]     pos_r;
  logic [DMG_W-1:0]     dmg_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // Table-wide state.
  logic [LCW-1:0] live_count;
  logic           mode_bit;
  logic [LCW-1:0] tally;
  logic [IW-1:0]  used_idx;

  // Read stream: issue, data, multiply.
  logic          rd_en;
  logic [IW-1:0] iss_idx;
  logic          d_vld;
  logic [IW-1:0] d_idx;
  slot_word_t    d_word;
  logic          m_vld;
  logic [IW-1:0] m_idx;
  slot_word_t    m_word;
  logic [PROD_W-1:0] m_prod;
  logic          pipe_empty;

  // Hit slot search trackers.
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          zero_found;
  logic [IW-1:0] zero_idx;
  logic          old_found;
  logic [IW-1:0] old_idx;
  logic [AGE_W-1:0] old_age;
  logic [IW-1:0] hit_idx;

  // Decay of the slot in the multiply stage.
  logic [DEC_W-1:0]  dec;
  logic [DIFF_W-1:0] diff;
  logic              survive;
  logic [AGE_W:0]    age_sum;
  slot_word_t        decayed;

  // Memory write port.
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_word_t    wr_data;

  logic in_xfer;
  logic out_load;

  assign in_xfer    = in_valid && in_ready;
  assign pipe_empty = !d_vld && !m_vld;
  assign rd_en      = (state == ST_SCAN);

  dhst_slot_mem #(
    .SLOTS(SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (iss_idx),
    .rd_data (d_word),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // A tick on an empty table stores the mode flag and goes straight to done.
          if (operation == OP_TICK && live_count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_idx == IW'(SLOTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_next = (op_r == OP_HIT) ? ST_HWRITE : ST_DONE;
        end
      end
      ST_HWRITE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------- item capture and read stream ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= op_t'(operation);
      tag_r     <= source_tag;
      pos_r     <= {pos_z, pos_y, pos_x};
      dmg_r     <= hit_damage;
      elapsed_r <= elapsed;
    end
    d_idx  <= iss_idx;
    m_idx  <= d_idx;
    m_word <= d_word;
    m_prod <= PROD_W'(d_word.damage) * PROD_W'(elapsed_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_idx <= '0;
      d_vld   <= 1'b0;
      m_vld   <= 1'b0;
    end else begin
      if (in_xfer) begin
        iss_idx <= '0;
      end else if (rd_en) begin
        iss_idx <= iss_idx + IW'(1);
      end
      d_vld <= rd_en;
      m_vld <= d_vld && (op_r == OP_TICK);
    end
  end

  // ---------------- hit slot search ----------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      match_found <= 1'b0;
      zero_found  <= 1'b0;
      old_found   <= 1'b0;
      match_idx   <= '0;
      zero_idx    <= '0;
      old_idx     <= '0;
      old_age     <= '0;
    end else if (d_vld && op_r == OP_HIT) begin
      if (!match_found && d_word.tag == tag_r) begin
        match_found <= 1'b1;
        match_idx   <= d_idx;
      end
      if (!zero_found && d_word.damage == '0) begin
        zero_found <= 1'b1;
        zero_idx   <= d_idx;
      end
      // Strictly older only: the earliest slot keeps a tie.
      if (!old_found || d_word.age > old_age) begin
        old_found <= 1'b1;
        old_idx   <= d_idx;
        old_age   <= d_word.age;
      end
    end
  end

  always_comb begin
    if (match_found) begin
      hit_idx = match_idx;
    end else if (zero_found) begin
      hit_idx = zero_idx;
    end else begin
      hit_idx = old_idx;
    end
  end

  // ---------------- tick decay ----------------
  always_comb begin
    dec     = m_prod[PROD_W-1:DEC_SHIFT];
    diff    = DIFF_W'(m_word.damage) - DIFF_W'(dec);
    // Below the floor, negative included, drops the slot.
    survive = !diff[DIFF_W-1] && (diff >= DAMAGE_FLOOR);
    age_sum = (AGE_W + 1)'(m_word.age) + (AGE_W + 1)'(elapsed_r);
    decayed = m_word;
    if (survive) begin
      decayed.damage = diff[DMG_W-1:0];
      decayed.age    = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
    end else begin
      decayed.damage = '0;
      decayed.age    = '0;
      decayed.tag    = '0;
    end
  end

  // ---------------- write port ----------------
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = m_idx;
    wr_data = decayed;
    if (state == ST_HWRITE) begin
      wr_en          = 1'b1;
      wr_addr        = hit_idx;
      wr_data.tag    = tag_r;
      wr_data.pos    = pos_r;
      wr_data.damage = dmg_r;
      wr_data.age    = AGE_ONE;
    end else if (m_vld && m_word.damage != '0) begin
      wr_en = 1'b1;
    end
  end

  // ---------------- counts, mode and result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      mode_bit   <= 1'b0;
      tally      <= '0;
      used_idx   <= '0;
    end else begin
      if (in_xfer) begin
        tally    <= '0;
        used_idx <= '0;
        if (operation == OP_TICK) begin
          mode_bit <= bubble_flag;
        end
      end else if (m_vld && m_word.damage != '0 && survive) begin
        tally <= tally + LCW'(1);
      end
      if (state == ST_HWRITE) begin
        used_idx <= hit_idx;
        if (live_count < LCW'(SLOTS)) begin
          live_count <= live_count + LCW'(1);
        end
      end
      if (state == ST_DRAIN && pipe_empty && op_r == OP_TICK) begin
        live_count <= tally;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      active_count <= ACTIVE_W'(live_count);
      slot_used    <= USED_W'(used_idx);
      bubble_mode  <= mode_bit;
    end
  end

  // ---------------- assertions ----------------
  `DHST_ASSERT_NEXT(a_xfer_leaves_idle, in_xfer, state != ST_IDLE, "idle after transfer in")
  `DHST_ASSERT_NOW(a_count_bound, 1'b1, live_count <= LCW'(SLOTS), "live count above slots")
  `DHST_ASSERT_NOW(a_no_rw_overlap, wr_en && rd_en, wr_addr != iss_idx, "read meets write")
  `DHST_ASSERT_NEXT(a_hit_write_done, state == ST_HWRITE, state == ST_DONE, "hit write stray")

endmodule
